// ===== sv/mvma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvma_pkg;

  localparam int MaxColsDefault = 1024;
  localparam int CfgAddrW       = 4;
  localparam int CfgDataW       = 32;
  localparam int QueueDepth     = 4;

  localparam logic [1:0] RegAlpha = 2'd0;
  localparam logic [1:0] RegBeta  = 2'd1;
  localparam logic [1:0] RegCols  = 2'd2;
  localparam logic [1:0] RegRows  = 2'd3;

  localparam logic ActVector = 1'b0;
  localparam logic ActMatrix = 1'b1;

  localparam logic [15:0] AlphaReset = 16'd4096;
  localparam logic [15:0] BetaReset  = 16'd4096;
  localparam logic [10:0] ColsReset  = 11'd1024;
  localparam logic [15:0] RowsReset  = 16'd1;

  typedef struct packed {
    logic              action;
    logic [9:0]        vec_index;
    logic signed [15:0] value;
    logic signed [15:0] y_old;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] y_new;
    logic [15:0]        row_number;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] alpha_gain;
    logic signed [15:0] beta_gain;
    logic [10:0]        cols_in_use;
    logic [15:0]        rows_in_use;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic signed [15:0] xv;
    logic signed [15:0] y_old;
    logic               eor;
    logic [15:0]        row;
    logic               last;
  } elem_t;

endpackage

`default_nettype wire

// ===== sv/mvma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvma_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/mvma_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvma_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  mvma_pkg::elem_t      data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output mvma_pkg::elem_t      data_o,
  output logic                 empty_o
);
  import mvma_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  elem_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Queue written while full.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("Queue count out of range.");

endmodule

`default_nettype wire

// ===== sv/mvma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvma_front #(
  parameter int MaxCols = mvma_pkg::MaxColsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  mvma_pkg::cfg_t     cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  mvma_pkg::in_item_t in_data_i,
  output logic               push_o,
  output mvma_pkg::elem_t    elem_o,
  input  wire logic          full_i
);
  import mvma_pkg::*;

  localparam int CntW = $clog2(MaxCols);

  logic [CntW-1:0]   cc_q, cc_d;
  logic [15:0]       rc_q, rc_d;
  logic              pend_q, pend_d;
  logic signed [15:0] pvalue_q, py_old_q;
  logic              peor_q, plast_q;
  logic [15:0]       prow_q;

  logic              accept, is_mat, wr_en, rd_en, eor, last;
  logic [31:0]       cols32, cols_clamp;
  logic [CntW:0]     cols_eff;
  logic [15:0]       rows_eff;
  logic [15:0]       ram_rdata;

  assign in_stall_o = pend_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_mat     = (in_data_i.action == ActMatrix);
  assign wr_en      = accept && !is_mat && (32'(in_data_i.vec_index) < MaxCols);
  assign rd_en      = accept && is_mat;
  assign push_o     = pend_q && !full_i;

  always_comb begin
    cols32 = 32'(cfg_i.cols_in_use);
    if (cols32 == 32'd0) begin
      cols_clamp = 32'd1;
    end else if (cols32 > 32'(MaxCols)) begin
      cols_clamp = 32'(MaxCols);
    end else begin
      cols_clamp = cols32;
    end
    cols_eff = cols_clamp[CntW:0];
    rows_eff = (cfg_i.rows_in_use == 16'd0) ? 16'd1 : cfg_i.rows_in_use;
    eor  = (({1'b0, cc_q} + 1'b1) >= cols_eff);
    last = (({1'b0, rc_q} + 17'd1) >= {1'b0, rows_eff});
  end

  always_comb begin
    cc_d   = cc_q;
    rc_d   = rc_q;
    pend_d = pend_q;
    if (rd_en) begin
      pend_d = 1'b1;
      if (eor) begin
        cc_d = '0;
        rc_d = last ? 16'd0 : rc_q + 16'd1;
      end else begin
        cc_d = cc_q + 1'b1;
      end
    end else if (push_o) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      rc_q   <= '0;
      pend_q <= 1'b0;
    end else begin
      cc_q   <= cc_d;
      rc_q   <= rc_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pvalue_q <= in_data_i.value;
      py_old_q <= in_data_i.y_old;
      peor_q   <= eor;
      plast_q  <= last;
      prow_q   <= rc_q;
    end
  end

  mvma_ram #(
    .Width (16),
    .Depth (MaxCols)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (CntW'(in_data_i.vec_index)),
    .wdata_i (in_data_i.value),
    .re_i    (rd_en),
    .raddr_i (cc_q),
    .rdata_o (ram_rdata)
  );

  assign elem_o = '{value: pvalue_q, xv: $signed(ram_rdata), y_old: py_old_q,
                    eor: peor_q, row: prow_q, last: plast_q};

endmodule

`default_nettype wire

// ===== sv/mvma_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvma_back #(
  parameter int MaxCols = mvma_pkg::MaxColsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  mvma_pkg::cfg_t      cfg_i,
  input  mvma_pkg::elem_t     elem_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output mvma_pkg::out_item_t out_data_o
);
  import mvma_pkg::*;

  localparam int CntW  = $clog2(MaxCols);
  localparam int AccW  = CntW + 33;
  localparam int HiW   = AccW - 24;
  localparam int PHiW  = HiW + 16;
  localparam int YW    = PHiW + 1;

  logic               advance;

  logic               s1_valid_q;
  logic signed [31:0] s1_prod_q;
  logic signed [15:0] s1_y_old_q;
  logic               s1_eor_q, s1_last_q;
  logic [15:0]        s1_row_q;

  logic signed [AccW-1:0] acc_q, acc_d, acc_total;

  logic                   s2_valid_q;
  logic signed [AccW-1:0] s2_acc_q;
  logic signed [15:0]     s2_y_old_q;
  logic                   s2_last_q;
  logic [15:0]            s2_row_q;

  logic                   s3_valid_q;
  logic signed [PHiW-1:0] p_hi_q;
  logic signed [40:0]     p_lo_q;
  logic signed [31:0]     by_q;
  logic                   s3_last_q;
  logic [15:0]            s3_row_q;

  logic signed [HiW-1:0]  acc_hi;
  logic [23:0]            acc_lo;
  logic signed [45:0]     low_sum;
  logic signed [YW-1:0]   y_full;
  logic signed [15:0]     y_sat;
  logic [YW-16:0]         y_upper;

  logic                   out_valid_q;
  out_item_t              out_data_q;

  assign advance = !(out_valid_q && out_stall_i);
  assign pop_o   = advance && !empty_i;

  assign acc_total = acc_q + {{(AccW-32){s1_prod_q[31]}}, s1_prod_q};
  assign acc_hi    = s2_acc_q[AccW-1:24];
  assign acc_lo    = s2_acc_q[23:0];

  always_comb begin
    acc_d = acc_q;
    if (advance && s1_valid_q) begin
      acc_d = s1_eor_q ? '0 : acc_total;
    end
  end

  always_comb begin
    low_sum = {{5{p_lo_q[40]}}, p_lo_q} + {{2{by_q[31]}}, by_q, 12'b0}
            + 46'sd8388608;
    y_full  = {p_hi_q[PHiW-1], p_hi_q}
            + {{(YW-22){low_sum[45]}}, low_sum[45:24]};
    y_upper = y_full[YW-1:15];
    if ((&y_upper) || !(|y_upper)) begin
      y_sat = y_full[15:0];
    end else if (y_full[YW-1]) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = 16'sh7fff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      acc_q <= acc_d;
      if (advance) begin
        s1_valid_q  <= !empty_i;
        s2_valid_q  <= s1_valid_q && s1_eor_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q  <= elem_i.value * elem_i.xv;
      s1_y_old_q <= elem_i.y_old;
      s1_eor_q   <= elem_i.eor;
      s1_last_q  <= elem_i.last;
      s1_row_q   <= elem_i.row;

      s2_acc_q   <= acc_total;
      s2_y_old_q <= s1_y_old_q;
      s2_last_q  <= s1_last_q;
      s2_row_q   <= s1_row_q;

      p_hi_q     <= cfg_i.alpha_gain * acc_hi;
      p_lo_q     <= cfg_i.alpha_gain * $signed({1'b0, acc_lo});
      by_q       <= cfg_i.beta_gain * s2_y_old_q;
      s3_last_q  <= s2_last_q;
      s3_row_q   <= s2_row_q;

      out_data_q <= '{y_new: y_sat, row_number: s3_row_q, last_row: s3_last_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_valid_q && s1_eor_q) |=> (acc_q == '0))
    else $error("Accumulator not cleared at end of row.");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q))
    else $error("Result appeared without a finished row.");

endmodule

`default_nettype wire

// ===== sv/matrix_vector_multiply_accumulate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload               Handshake
// in        input      mvma_pkg::in_item_t   in_valid_i / in_stall_o
// out       output     mvma_pkg::out_item_t  out_valid_o / out_stall_i
// config    input      APB, 4 registers      psel, penable, pwrite, pready
//
// One request is accepted per cycle unless the front holds an element and the
// queue is full; the vector store read in the front, the queue and the
// four-stage back pipeline lie between a row's end and its result. Reset clears
// the counters, the accumulator and the queue at once; the vector store holds
// no defined value until written and gets no clearing pass. A stalled output
// holds the back pipeline, and the queue then fills until the input is stalled.

module matrix_vector_multiply_accumulate #(
  parameter int MaxCols = mvma_pkg::MaxColsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  mvma_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mvma_pkg::out_item_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mvma_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [mvma_pkg::CfgDataW-1:0] pwdata,
  output logic      [mvma_pkg::CfgDataW-1:0] prdata,
  output logic                               pready
);
  import mvma_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_we;
  logic [1:0]  reg_sel;
  logic        push, full, pop, empty;
  elem_t       q_in, q_out;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_gain  <= AlphaReset;
      cfg_q.beta_gain   <= BetaReset;
      cfg_q.cols_in_use <= ColsReset;
      cfg_q.rows_in_use <= RowsReset;
    end else if (cfg_we) begin
      unique case (reg_sel)
        RegAlpha: cfg_q.alpha_gain  <= pwdata[15:0];
        RegBeta:  cfg_q.beta_gain   <= pwdata[15:0];
        RegCols:  cfg_q.cols_in_use <= pwdata[10:0];
        RegRows:  cfg_q.rows_in_use <= pwdata[15:0];
        default:  cfg_q.rows_in_use <= cfg_q.rows_in_use;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegAlpha: prdata = {16'b0, cfg_q.alpha_gain};
      RegBeta:  prdata = {16'b0, cfg_q.beta_gain};
      RegCols:  prdata = {21'b0, cfg_q.cols_in_use};
      RegRows:  prdata = {16'b0, cfg_q.rows_in_use};
      default:  prdata = '0;
    endcase
  end

  mvma_front #(
    .MaxCols (MaxCols)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .elem_o     (q_in),
    .full_i     (full)
  );

  mvma_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  mvma_back #(
    .MaxCols (MaxCols)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .elem_i      (q_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_matrix_vector_multiply_accumulate.sv =====
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_accumulate;
  import mvma_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 300;
  localparam int NumPhases    = 9;
  localparam int BigPhase     = 4;
  localparam int PhaseItems   = 130;
  localparam int BigItems     = 256;
  localparam int DirectedLen  = 29;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    in_item_t    req;
    bit          typed;
    out_item_t   y_typed;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  logic signed [15:0] x_store [MaxColsDefault];
  bit                 x_written [MaxColsDefault];
  longint             dot_sum;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic signed [15:0] alpha_q;
  logic signed [15:0] beta_q;
  logic [10:0]        cols_q;
  logic [15:0]        rows_q;

  out_item_t row_results_due [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 31;
  int        recv_idle_pct = 52;
  bit        hold_pending = 1'b0;

  matrix_vector_multiply_accumulate dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit gemv_step(input in_item_t req, output out_item_t res);
    int unsigned n_cols;
    int unsigned n_rows;
    longint      mix;
    longint      y;
    res = '0;
    if (req.action == ActVector) begin
      x_store[req.vec_index] = req.value;
      x_written[req.vec_index] = 1'b1;
      return 1'b0;
    end
    n_cols = (cols_q == 0) ? 1 : ((cols_q > MaxColsDefault) ? MaxColsDefault : cols_q);
    n_rows = (rows_q == 0) ? 1 : rows_q;
    dot_sum += longint'($signed(req.value)) * longint'(x_store[col_pos]);
    if (col_pos + 1 < n_cols) begin
      col_pos++;
      return 1'b0;
    end
    mix = longint'(alpha_q) * dot_sum + longint'(beta_q) * longint'($signed(req.y_old)) * 4096;
    y = (mix + 64'sd8388608) >>> 24;
    if (y > 32767) begin
      y = 32767;
    end else if (y < -32768) begin
      y = -32768;
    end
    res.y_new = y[15:0];
    res.row_number = row_pos[15:0];
    res.last_row = (row_pos + 1 >= n_rows);
    dot_sum = 0;
    col_pos = 0;
    row_pos = res.last_row ? 0 : row_pos + 1;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3, 4: return 16'($urandom_range(8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic step_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
    step_t s;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.req = '0;
    s.typed = 1'b0;
    s.y_typed = '0;
    return s;
  endfunction

  function automatic step_t req_row(input logic act, input logic [9:0] idx,
                                    input logic [15:0] val, input logic [15:0] y_prev);
    step_t s;
    s.is_cfg = 1'b0;
    s.reg_idx = RegAlpha;
    s.reg_val = '0;
    s.req.action = act;
    s.req.vec_index = idx;
    s.req.value = val;
    s.req.y_old = y_prev;
    s.typed = 1'b0;
    s.y_typed = '0;
    return s;
  endfunction

  function automatic step_t chk_row(input logic [15:0] val, input logic [15:0] y_prev,
                                    input logic [15:0] y_want, input logic [15:0] row,
                                    input logic last);
    step_t s;
    s = req_row(ActMatrix, 10'd0, val, y_prev);
    s.typed = 1'b1;
    s.y_typed.y_new = y_want;
    s.y_typed.row_number = row;
    s.y_typed.last_row = last;
    return s;
  endfunction

  task automatic push_request(input in_item_t req, input bit typed, input out_item_t y_typed);
    out_item_t y_pred;
    bit        has_row;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    has_row = gemv_step(req, y_pred);
    if (has_row) row_results_due.push_back(typed ? y_typed : y_pred);
    @(negedge clk_i);
  endtask

  task automatic push_matrix_element();
    in_item_t req;
    if (!x_written[col_pos]) begin
      req.action = ActVector;
      req.vec_index = col_pos[9:0];
      req.value = pick_value();
      req.y_old = 16'($urandom);
      push_request(req, 1'b0, '0);
    end
    req.action = ActMatrix;
    req.vec_index = 10'($urandom);
    req.value = pick_value();
    req.y_old = pick_value();
    push_request(req, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      RegAlpha: alpha_q = val;
      RegBeta:  beta_q = val;
      RegCols:  cols_q = val[10:0];
      default:  rows_q = val;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_rows_drained();
    in_valid_i <= 1'b0;
    while (row_results_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_pending = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_rows
    out_item_t y_due;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (row_results_due.size() == 0) begin
        $display("%0t: unexpected row result, expected none, actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        y_due = row_results_due.pop_front();
        if (out_data_o.y_new !== y_due.y_new) begin
          $display("%0t: y_new expected %h actual %h", $time, y_due.y_new, out_data_o.y_new);
          mismatch_count++;
        end
        if (out_data_o.row_number !== y_due.row_number) begin
          $display("%0t: row_number expected %h actual %h", $time, y_due.row_number,
                   out_data_o.row_number);
          mismatch_count++;
        end
        if (out_data_o.last_row !== y_due.last_row) begin
          $display("%0t: last_row expected %b actual %b", $time, y_due.last_row,
                   out_data_o.last_row);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_matrix_vector_multiply_accumulate: errors");
      $finish;
    end
  end

  initial begin
    step_t       directed [DirectedLen];
    in_item_t    noise;
    int          n_items;
    logic [15:0] cols_pick;
    logic [15:0] rows_pick;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    alpha_q    = AlphaReset;
    beta_q     = BetaReset;
    cols_q     = ColsReset;
    rows_q     = RowsReset;
    dot_sum    = 0;
    col_pos    = 0;
    row_pos    = 0;

    directed = '{
      cfg_row(RegCols, 16'd1),
      cfg_row(RegRows, 16'd3),
      req_row(ActVector, 10'd0, 16'h1000, 16'h0000),
      chk_row(16'h1000, 16'h0000, 16'h1000, 16'd0, 1'b0),
      chk_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1, 1'b0),
      chk_row(16'h8000, 16'h8000, 16'h8000, 16'd2, 1'b1),
      cfg_row(RegAlpha, 16'h8000),
      cfg_row(RegBeta, 16'h0000),
      chk_row(16'h1000, 16'h04D2, 16'h8000, 16'd0, 1'b0),
      cfg_row(RegAlpha, 16'h7FFF),
      cfg_row(RegBeta, 16'h7FFF),
      chk_row(16'h0000, 16'h0000, 16'h0000, 16'd1, 1'b0),
      cfg_row(RegCols, 16'd0),
      chk_row(16'h1000, 16'h1000, 16'h7FFF, 16'd2, 1'b1),
      cfg_row(RegAlpha, 16'h1000),
      cfg_row(RegBeta, 16'h1000),
      cfg_row(RegCols, 16'd2),
      cfg_row(RegRows, 16'd5),
      req_row(ActVector, 10'd1, 16'hF000, 16'h0000),
      req_row(ActVector, 10'd1023, 16'h7FFF, 16'hFFFF),
      req_row(ActMatrix, 10'd0, 16'h2000, 16'h0064),
      req_row(ActVector, 10'd0, 16'h0800, 16'h0000),
      chk_row(16'h1000, 16'h0064, 16'h1064, 16'd0, 1'b0),
      req_row(ActMatrix, 10'd0, 16'h0000, 16'h0000),
      cfg_row(RegCols, 16'd1),
      req_row(ActMatrix, 10'h3FF, 16'hB1E0, 16'h004D),
      cfg_row(RegRows, 16'd1),
      req_row(ActMatrix, 10'h2AA, 16'h0005, 16'hFFFD),
      cfg_row(RegRows, 16'hFFFF)
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirectedLen; i++) begin
      if (directed[i].is_cfg) begin
        wait_rows_drained();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        push_request(directed[i].req, directed[i].typed, directed[i].y_typed);
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      send_idle_pct = (phase < 3) ? 31 : ((phase < 6) ? 52 : 0);
      recv_idle_pct = (phase < 3) ? 52 : ((phase < 6) ? 31 : 0);
      wait_rows_drained();
      write_reg(RegAlpha, ($urandom_range(3) == 0) ? pick_value()
                                                   : 16'($urandom_range(8191)) - 16'd4096);
      write_reg(RegBeta, pick_value());
      if (phase == BigPhase) begin
        cols_pick = 16'd2047;
        rows_pick = 16'd1;
        n_items = BigItems;
      end else begin
        cols_pick = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(8, 1));
        case ($urandom_range(5))
          0: rows_pick = 16'd0;
          1: rows_pick = 16'hFFFF;
          default: rows_pick = 16'($urandom_range(6, 1));
        endcase
        n_items = PhaseItems;
      end
      write_reg(RegCols, cols_pick);
      write_reg(RegRows, rows_pick);
      if (phase == 1) hold_pending = 1'b1;
      for (int k = 0; k < n_items; k++) begin
        if (phase == 2 && k == n_items / 2) wait_rows_drained();
        if (phase != BigPhase && $urandom_range(9) == 0) begin
          noise.action = ActVector;
          noise.vec_index = 10'($urandom);
          noise.value = pick_value();
          noise.y_old = 16'($urandom);
          push_request(noise, 1'b0, '0);
        end
        push_matrix_element();
      end
    end

    wait_rows_drained();
    if (mismatch_count == 0) begin
      $display("tb_matrix_vector_multiply_accumulate: clean");
    end else begin
      $display("tb_matrix_vector_multiply_accumulate: errors");
    end
    $finish;
  end

endmodule
